// File: hdl/gpfr_pkg.sv
// Shared types and constants for the guarded packet frame receiver.
package gpfr_pkg;

	typedef struct packed {
		logic       req_type;
		logic [7:0] rx_byte;
	} req_t;

	typedef struct packed {
		logic [1:0]  event_kind;
		logic [7:0]  command_code;
		logic [31:0] payload_length;
		logic [31:0] byte_offset;
		logic [7:0]  payload_byte;
		logic        last_of_packet;
	} rsp_t;

	localparam logic       REQ_BYTE = 1'b0;
	localparam logic       REQ_TICK = 1'b1;

	localparam logic [1:0] EVT_HEADER = 2'd0;
	localparam logic [1:0] EVT_DATA   = 2'd1;
	localparam logic [1:0] EVT_EMPTY  = 2'd2;

	localparam logic [3:0]  GUARD_BYTES  = 4'd4;
	localparam logic [3:0]  HEADER_BYTES = 4'd9;
	localparam logic [16:0] IDLE_MAX     = 17'h1FFFF;
	localparam logic [15:0] GAP_TIMEOUT_RST = 16'd100;

	function automatic logic [7:0] guard_byte(input logic [1:0] idx);
		logic [7:0] b;
		unique case (idx)
			2'd0: b = 8'h4D;
			2'd1: b = 8'h43;
			2'd2: b = 8'h48;
			default: b = 8'h50;
		endcase
		return b;
	endfunction

endpackage

// File: hdl/gpfr_parser.sv
// Frame state and per-item decode: guard hunt, header gather, payload stream.
module gpfr_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  gpfr_pkg::req_t     item,
	input  logic [15:0]        gap_timeout,
	output logic               has_result,
	output gpfr_pkg::rsp_t     result
);

	logic        in_payload_q, in_payload_d;
	logic [3:0]  header_count_q, header_count_d;
	logic [31:0] length_q, length_d;
	logic [7:0]  command_q, command_d;
	logic [31:0] payload_count_q, payload_count_d;
	logic [16:0] idle_ticks_q, idle_ticks_d;
	logic        seen_q, seen_d;

	logic        timed_out;
	logic        in_pl;
	logic [3:0]  hc;
	logic [3:0]  hc_inc;
	logic [31:0] pc;
	logic [31:0] pc_inc;
	logic        last;

	always_comb begin
		timed_out = seen_q && (idle_ticks_q > {1'b0, gap_timeout});
		in_pl     = in_payload_q && !timed_out;
		hc        = timed_out ? 4'd0 : header_count_q;
		pc        = timed_out ? 32'd0 : payload_count_q;
		hc_inc    = hc + 4'd1;
		pc_inc    = pc + 32'd1;
		last      = (pc_inc == length_q);

		in_payload_d    = in_payload_q;
		header_count_d  = header_count_q;
		length_d        = length_q;
		command_d       = command_q;
		payload_count_d = payload_count_q;
		idle_ticks_d    = idle_ticks_q;
		seen_d          = seen_q;
		has_result      = 1'b0;
		result          = '0;

		if (item.req_type == gpfr_pkg::REQ_TICK) begin
			if (idle_ticks_q != gpfr_pkg::IDLE_MAX) begin
				idle_ticks_d = idle_ticks_q + 17'd1;
			end
		end else begin
			in_payload_d    = in_pl;
			header_count_d  = hc;
			payload_count_d = pc;
			idle_ticks_d    = '0;
			seen_d          = 1'b1;
			if (!in_pl) begin
				if (hc_inc <= gpfr_pkg::GUARD_BYTES) begin
					// restart the hunt on a mismatch; the failing byte is not retried
					header_count_d = (item.rx_byte == gpfr_pkg::guard_byte(hc[1:0]))
						? hc_inc : 4'd0;
				end else if (hc_inc < gpfr_pkg::HEADER_BYTES) begin
					// little-endian: shift each byte in from the top
					length_d       = {item.rx_byte, length_q[31:8]};
					header_count_d = hc_inc;
				end else begin
					command_d              = item.rx_byte;
					header_count_d         = '0;
					payload_count_d        = '0;
					in_payload_d           = 1'b1;
					has_result             = 1'b1;
					result.event_kind      = gpfr_pkg::EVT_HEADER;
					result.command_code    = item.rx_byte;
					result.payload_length  = length_q;
				end
			end else if (length_q == 32'd0) begin
				// empty packet: drop this byte and close the frame
				in_payload_d          = 1'b0;
				payload_count_d       = '0;
				has_result            = 1'b1;
				result.event_kind     = gpfr_pkg::EVT_EMPTY;
				result.command_code   = command_q;
				result.last_of_packet = 1'b1;
			end else begin
				payload_count_d       = last ? 32'd0 : pc_inc;
				in_payload_d          = !last;
				has_result            = 1'b1;
				result.event_kind     = gpfr_pkg::EVT_DATA;
				result.command_code   = command_q;
				result.payload_length = length_q;
				result.byte_offset    = pc;
				result.payload_byte   = item.rx_byte;
				result.last_of_packet = last;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q    <= 1'b0;
			header_count_q  <= '0;
			length_q        <= '0;
			command_q       <= '0;
			payload_count_q <= '0;
			idle_ticks_q    <= '0;
			seen_q          <= 1'b0;
		end else if (step) begin
			in_payload_q    <= in_payload_d;
			header_count_q  <= header_count_d;
			length_q        <= length_d;
			command_q       <= command_d;
			payload_count_q <= payload_count_d;
			idle_ticks_q    <= idle_ticks_d;
			seen_q          <= seen_d;
		end
	end

endmodule

// File: hdl/guarded_packet_frame_receiver_unit.sv
// Top level of the guarded packet frame receiver: input register, parser, result register.
// Each item is a received byte or one time tick. The block hunts for the guard bytes
// 4D 43 48 50, gathers a 32-bit little-endian payload length and a command byte,
// reports the header, then streams every payload byte with its offset and marks the
// last; a zero-length packet is closed by the next byte, which is dropped. A byte
// arriving after more than cfg_data ticks of silence discards any partial frame.
// Items pass through one input register and one result register, and one item is
// accepted every cycle unless the staged item has a result and the result register is
// full and stalled. cfg_data is taken at any cycle (cfg_ready is always high) and must
// only be written while no item is in flight.
module guarded_packet_frame_receiver_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  gpfr_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output gpfr_pkg::rsp_t  rsp,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [15:0]     cfg_data
);

	logic           valid_s1;
	gpfr_pkg::req_t item_s1;
	logic           rsp_valid_q;
	gpfr_pkg::rsp_t rsp_q;
	logic [15:0]    gap_timeout_q;
	logic           has_result;
	gpfr_pkg::rsp_t result;
	logic           advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_timeout_q <= gpfr_pkg::GAP_TIMEOUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			gap_timeout_q <= cfg_data;
		end
	end

	// hold the stage only when it has a result and the result register cannot take it
	assign advance   = valid_s1 && (!has_result || !rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			item_s1 <= req;
		end
	end

	gpfr_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.item        (item_s1),
		.gap_timeout (gap_timeout_q),
		.has_result  (has_result),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance && has_result) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef NO_ASSERTIONS
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1)
		else $error("input stalled with an empty stage");

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && has_result) |=> (rsp_valid && rsp == $past(result)))
		else $error("result transfer lost");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |-> !(advance && has_result))
		else $error("stalled result overwritten");

	a_empty_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.event_kind == gpfr_pkg::EVT_EMPTY) |->
		(rsp.last_of_packet && rsp.payload_length == 32'd0))
		else $error("empty packet event malformed");
`endif

endmodule
